// ===== rtl/tsfd_pkg.sv =====
// ----------------------------------------------------------------------------
// tsfd_pkg
// Shared types and constants for the triangle strip and fan decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package tsfd_pkg;

  localparam int unsigned IdxW    = 15;
  localparam int unsigned TexW    = 16;
  localparam int unsigned CountW  = 16;
  localparam int unsigned LimitW  = 16;
  localparam int unsigned InDataW  = 64;
  localparam int unsigned OutDataW = 144;
  localparam int unsigned OutUserW = 2;

  localparam logic [LimitW-1:0] FaceLimitReset = 16'hFFFF;

  // record kinds carried on the input tuser
  localparam logic ReqCommand = 1'b0;
  localparam logic ReqVertex  = 1'b1;

  // one triangle corner: vertex index with its texel coordinates
  typedef struct packed {
    logic signed [TexW-1:0] tex_t;
    logic signed [TexW-1:0] tex_s;
    logic [IdxW-1:0]        index;
  } corner_t;

  typedef struct packed {
    logic                     req_type;
    logic signed [CountW-1:0] run_count;
    corner_t                  vertex;
  } in_item_t;

  typedef struct packed {
    corner_t corner0;
    corner_t corner1;
    corner_t corner2;
    logic    mesh_done;
    logic    limit_hit;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/tsfd_core.sv =====
// ----------------------------------------------------------------------------
// tsfd_core
// Run state and triangle assembly; one record per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tsfd_core (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          item_valid_i,
  input  tsfd_pkg::in_item_t           item_i,
  input  wire [tsfd_pkg::LimitW-1:0]   face_limit_i,
  output logic                         res_valid_o,
  output tsfd_pkg::result_t            res_o
);

  logic                        fan_mode_q, fan_mode_d;
  logic [tsfd_pkg::IdxW-1:0]   run_left_q, run_left_d;
  logic [1:0]                  corners_seen_q, corners_seen_d;
  tsfd_pkg::corner_t           held_first_q, held_first_d;
  tsfd_pkg::corner_t           held_second_q, held_second_d;
  logic                        odd_q, odd_d;
  logic [tsfd_pkg::LimitW-1:0] faces_q, faces_d;
  logic                        stopped_q, stopped_d;

  logic [tsfd_pkg::CountW-1:0] cnt;
  logic [tsfd_pkg::CountW-1:0] mag;
  logic                        limit_reached;

  assign cnt           = item_i.run_count;
  assign mag           = 16'd0 - cnt;
  assign limit_reached = faces_q >= face_limit_i;

  always_comb begin
    fan_mode_d     = fan_mode_q;
    run_left_d     = run_left_q;
    corners_seen_d = corners_seen_q;
    held_first_d   = held_first_q;
    held_second_d  = held_second_q;
    odd_d          = odd_q;
    faces_d        = faces_q;
    stopped_d      = stopped_q;
    res_valid_o    = 1'b0;
    res_o          = '0;

    if (item_valid_i) begin
      if (item_i.req_type == tsfd_pkg::ReqCommand) begin
        if (cnt == '0) begin
          // terminator: clear the mesh, report done unless already reported
          fan_mode_d     = 1'b0;
          run_left_d     = '0;
          corners_seen_d = '0;
          held_first_d   = '0;
          held_second_d  = '0;
          odd_d          = 1'b0;
          faces_d        = '0;
          stopped_d      = 1'b0;
          if (!stopped_q) begin
            res_valid_o     = 1'b1;
            res_o.mesh_done = 1'b1;
          end
        end else if (stopped_q) begin
          // dropped
        end else if (limit_reached) begin
          stopped_d       = 1'b1;
          run_left_d      = '0;
          res_valid_o     = 1'b1;
          res_o.mesh_done = 1'b1;
          res_o.limit_hit = 1'b1;
        end else begin
          fan_mode_d     = cnt[tsfd_pkg::CountW-1];
          if (cnt[tsfd_pkg::CountW-1]) begin
            // largest fan saturates
            run_left_d = mag[tsfd_pkg::CountW-1] ? '1 : mag[tsfd_pkg::IdxW-1:0];
          end else begin
            run_left_d = cnt[tsfd_pkg::IdxW-1:0];
          end
          corners_seen_d = '0;
          odd_d          = 1'b0;
        end
      end else if (!stopped_q && run_left_q != '0) begin
        priority if (corners_seen_q == 2'd0) begin
          held_first_d   = item_i.vertex;
          corners_seen_d = 2'd1;
          run_left_d     = run_left_q - 1'b1;
        end else if (corners_seen_q == 2'd1) begin
          held_second_d  = item_i.vertex;
          corners_seen_d = 2'd2;
          run_left_d     = run_left_q - 1'b1;
        end else if (limit_reached) begin
          stopped_d       = 1'b1;
          run_left_d      = '0;
          res_valid_o     = 1'b1;
          res_o.mesh_done = 1'b1;
          res_o.limit_hit = 1'b1;
        end else begin
          run_left_d    = run_left_q - 1'b1;
          res_valid_o   = 1'b1;
          res_o.corner2 = item_i.vertex;
          if (fan_mode_q) begin
            res_o.corner0 = held_first_q;
            res_o.corner1 = held_second_q;
            held_second_d = item_i.vertex;
          end else begin
            // alternate triangles swap the held pair to keep the winding
            res_o.corner0 = odd_q ? held_second_q : held_first_q;
            res_o.corner1 = odd_q ? held_first_q : held_second_q;
            held_first_d  = held_second_q;
            held_second_d = item_i.vertex;
            odd_d         = ~odd_q;
          end
          faces_d = faces_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fan_mode_q     <= 1'b0;
      run_left_q     <= '0;
      corners_seen_q <= '0;
      odd_q          <= 1'b0;
      faces_q        <= '0;
      stopped_q      <= 1'b0;
    end else begin
      fan_mode_q     <= fan_mode_d;
      run_left_q     <= run_left_d;
      corners_seen_q <= corners_seen_d;
      odd_q          <= odd_d;
      faces_q        <= faces_d;
      stopped_q      <= stopped_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_first_q  <= held_first_d;
    held_second_q <= held_second_d;
  end

endmodule

`default_nettype wire

// ===== rtl/tsfd_out_reg.sv =====
// ----------------------------------------------------------------------------
// tsfd_out_reg
// Result register holding one triangle or done flag until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module tsfd_out_reg (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  input  tsfd_pkg::result_t  in_data_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  output tsfd_pkg::result_t  out_data_o,
  input  wire                out_ready_i
);

  logic              valid_q;
  tsfd_pkg::result_t data_q;

  // free when empty or emptied this cycle
  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= in_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tri_strip_fan_decoder.sv =====
// ----------------------------------------------------------------------------
// tri_strip_fan_decoder
// Turns a stream of strip and fan commands with vertex records into a
// plain triangle list, with mesh done and face limit reporting.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                   carries
//  s_axis    in         s_axis_tvalid/tready        command or vertex record
//  m_axis    out        m_axis_tvalid/tready        triangle or done flags
//  cfg       in         cfg_wvalid_i/cfg_wready_o   face_limit
//
//  one record per cycle while m_axis is not stalled; a record is decoded in the
//  cycle it is accepted and its result, if any, appears on m_axis from the next cycle
//  throughput is set by the single result register: the input is taken
//  whenever that register is empty or being emptied in the same cycle
//  a stall on m_axis holds the result and stops s_axis the same cycle
//  reset clears the run state, the result register and sets face_limit to
//  its top value
//
`default_nettype none

module tri_strip_fan_decoder (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // record input
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  // run_count[15:0], vertex_index[30:16], tex_s[46:31], tex_t[62:47], zero
  input  wire [tsfd_pkg::InDataW-1:0]        s_axis_tdata,
  // req_type[0]
  input  wire [0:0]                          s_axis_tuser,
  // triangle output
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  // corner0_index[14:0], corner1_index[29:15], corner2_index[44:30],
  // corner0_s[60:45], corner0_t[76:61], corner1_s[92:77], corner1_t[108:93],
  // corner2_s[124:109], corner2_t[140:125], zero
  output logic [tsfd_pkg::OutDataW-1:0]      m_axis_tdata,
  // mesh_done[0], limit_hit[1]
  output logic [tsfd_pkg::OutUserW-1:0]      m_axis_tuser,
  // face limit register
  input  wire                                cfg_wvalid_i,
  output logic                               cfg_wready_o,
  input  wire [tsfd_pkg::LimitW-1:0]         cfg_wdata_i
);

  logic [tsfd_pkg::LimitW-1:0] face_limit_q;
  tsfd_pkg::in_item_t          item;
  logic                        accept;
  logic                        res_valid;
  tsfd_pkg::result_t           res;
  tsfd_pkg::result_t           out_res;

  // register writes are always taken
  assign cfg_wready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      face_limit_q <= tsfd_pkg::FaceLimitReset;
    end else if (cfg_wvalid_i) begin
      face_limit_q <= cfg_wdata_i;
    end
  end

  // unpack the record
  assign item.req_type     = s_axis_tuser[0];
  assign item.run_count    = s_axis_tdata[15:0];
  assign item.vertex.index = s_axis_tdata[30:16];
  assign item.vertex.tex_s = s_axis_tdata[46:31];
  assign item.vertex.tex_t = s_axis_tdata[62:47];

  assign accept = s_axis_tvalid && s_axis_tready;

  tsfd_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (accept),
    .item_i       (item),
    .face_limit_i (face_limit_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  tsfd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_data_i   (res),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (out_res),
    .out_ready_i (m_axis_tready)
  );

  // pack the triangle, lowest field first
  assign m_axis_tdata = {3'b000,
                         out_res.corner2.tex_t, out_res.corner2.tex_s,
                         out_res.corner1.tex_t, out_res.corner1.tex_s,
                         out_res.corner0.tex_t, out_res.corner0.tex_s,
                         out_res.corner2.index, out_res.corner1.index,
                         out_res.corner0.index};
  assign m_axis_tuser = {out_res.limit_hit, out_res.mesh_done};

endmodule

`default_nettype wire
